[sv/btok_pkg.sv]
package btok_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 16;
  localparam int unsigned LENGTH_WIDTH_DEF   = 16;
  localparam int unsigned FIELD_WIDTH        = 16;
  localparam int unsigned TOKEN_FIFO_DEPTH   = 4;

  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_OPEN      = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE     = 8'h5D;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;

  typedef logic [FIELD_WIDTH-1:0] field_t;

  typedef enum logic [2:0] {
    KIND_EOF     = 3'd0,
    KIND_OPEN    = 3'd1,
    KIND_CLOSE   = 3'd2,
    KIND_INTEGER = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_WORD    = 3'd5,
    KIND_ERROR   = 3'd6
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNTERMINATED = 2'd1,
    ERR_BAD_ESCAPE   = 2'd2
  } error_code_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    token_kind_e token_kind;
    error_code_e error_code;
    field_t      first_line;
    field_t      first_column;
    field_t      start_offset;
    field_t      token_length;
    logic        last_result;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } token_pair_t;

endpackage

[sv/btok_lexer.sv]
module btok_lexer #(
  parameter int unsigned POSITION_WIDTH = btok_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH   = btok_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  btok_pkg::in_word_t    in_word_i,
  output btok_pkg::token_pair_t tok_pair_o
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_INTEGER = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_WORD    = 3'd4
  } mode_e;

  typedef logic [POSITION_WIDTH-1:0] pos_t;
  typedef logic [LENGTH_WIDTH-1:0]   len_t;

  function automatic pos_t sat_pos(input pos_t v);
    return (v == {POSITION_WIDTH{1'b1}}) ? v : v + pos_t'(1);
  endfunction

  function automatic len_t sat_len(input len_t v);
    return (v == {LENGTH_WIDTH{1'b1}}) ? v : v + len_t'(1);
  endfunction

  function automatic btok_pkg::out_word_t make_tok(input btok_pkg::token_kind_e kind,
                                                   input btok_pkg::error_code_e err,
                                                   input pos_t line, input pos_t col,
                                                   input pos_t off, input len_t len);
    btok_pkg::out_word_t t;
    t.token_kind   = kind;
    t.error_code   = err;
    t.first_line   = btok_pkg::field_t'(line);
    t.first_column = btok_pkg::field_t'(col);
    t.start_offset = btok_pkg::field_t'(off);
    t.token_length = btok_pkg::field_t'(len);
    t.last_result  = 1'b0;
    return t;
  endfunction

  mode_e mode_q, mode_d;
  pos_t  line_q, line_d, col_q, col_d, off_q, off_d;
  pos_t  tline_q, tline_d, tcol_q, tcol_d, toff_q, toff_d;
  len_t  len_q, len_d;

  logic [7:0] c;
  logic       eot, is_space, is_digit, is_bracket, is_quote, is_nl, is_escape_ok;
  pos_t       adv_line, adv_col, adv_off;
  logic       pre_v, main_v, relex;
  btok_pkg::out_word_t pre_tok, main_tok;

  assign c   = in_word_i.char_code;
  assign eot = in_word_i.end_of_text;

  assign is_nl        = (c == btok_pkg::CHAR_NEWLINE);
  assign is_space     = (c == btok_pkg::CHAR_SPACE) ||
                        ((c >= btok_pkg::CHAR_TAB) && (c <= btok_pkg::CHAR_CR));
  assign is_digit     = (c >= btok_pkg::CHAR_ZERO) && (c <= btok_pkg::CHAR_NINE);
  assign is_bracket   = (c == btok_pkg::CHAR_OPEN) || (c == btok_pkg::CHAR_CLOSE);
  assign is_quote     = (c == btok_pkg::CHAR_QUOTE);
  assign is_escape_ok = (c == btok_pkg::CHAR_N) || (c == btok_pkg::CHAR_R) ||
                        (c == btok_pkg::CHAR_T) || is_quote ||
                        (c == btok_pkg::CHAR_BACKSLASH);

  assign adv_line = is_nl ? sat_pos(line_q) : line_q;
  assign adv_col  = is_nl ? pos_t'(1) : sat_pos(col_q);
  assign adv_off  = sat_pos(off_q);

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    off_d    = off_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    toff_d   = toff_q;
    len_d    = len_q;
    pre_v    = 1'b0;
    main_v   = 1'b0;
    relex    = 1'b0;
    pre_tok  = '0;
    main_tok = '0;
    if (eot) begin
      unique case (mode_q)
        MODE_INTEGER: begin
          pre_v   = 1'b1;
          pre_tok = make_tok(btok_pkg::KIND_INTEGER, btok_pkg::ERR_NONE,
                             tline_q, tcol_q, toff_q, len_q);
        end
        MODE_WORD: begin
          pre_v   = 1'b1;
          pre_tok = make_tok(btok_pkg::KIND_WORD, btok_pkg::ERR_NONE,
                             tline_q, tcol_q, toff_q, len_q);
        end
        MODE_STRING, MODE_ESCAPE: begin
          pre_v   = 1'b1;
          pre_tok = make_tok(btok_pkg::KIND_ERROR, btok_pkg::ERR_UNTERMINATED,
                             tline_q, tcol_q, toff_q, '0);
        end
        default: ;
      endcase
      main_v   = 1'b1;
      main_tok = make_tok(btok_pkg::KIND_EOF, btok_pkg::ERR_NONE,
                          line_q, col_q, off_q, '0);
      mode_d   = MODE_IDLE;
    end else begin
      unique case (mode_q)
        MODE_INTEGER: begin
          if (is_digit) begin
            len_d  = sat_len(len_q);
            line_d = adv_line;
            col_d  = adv_col;
            off_d  = adv_off;
          end else begin
            pre_v   = 1'b1;
            pre_tok = make_tok(btok_pkg::KIND_INTEGER, btok_pkg::ERR_NONE,
                               tline_q, tcol_q, toff_q, len_q);
            relex   = 1'b1;
          end
        end
        MODE_WORD: begin
          if (!(is_space || is_bracket || is_quote)) begin
            len_d  = sat_len(len_q);
            line_d = adv_line;
            col_d  = adv_col;
            off_d  = adv_off;
          end else begin
            pre_v   = 1'b1;
            pre_tok = make_tok(btok_pkg::KIND_WORD, btok_pkg::ERR_NONE,
                               tline_q, tcol_q, toff_q, len_q);
            relex   = 1'b1;
          end
        end
        MODE_STRING: begin
          len_d  = sat_len(len_q);
          line_d = adv_line;
          col_d  = adv_col;
          off_d  = adv_off;
          if (is_quote) begin
            pre_v   = 1'b1;
            pre_tok = make_tok(btok_pkg::KIND_STRING, btok_pkg::ERR_NONE,
                               tline_q, tcol_q, toff_q, sat_len(len_q));
            mode_d  = MODE_IDLE;
          end else if (c == btok_pkg::CHAR_BACKSLASH) begin
            mode_d = MODE_ESCAPE;
          end
        end
        MODE_ESCAPE: begin
          if (is_escape_ok) begin
            len_d  = sat_len(len_q);
            line_d = adv_line;
            col_d  = adv_col;
            off_d  = adv_off;
            mode_d = MODE_STRING;
          end else begin
            pre_v   = 1'b1;
            pre_tok = make_tok(btok_pkg::KIND_ERROR, btok_pkg::ERR_BAD_ESCAPE,
                               tline_q, tcol_q, toff_q, '0);
            relex   = 1'b1;
          end
        end
        default: relex = 1'b1;
      endcase
      if (relex) begin
        mode_d = MODE_IDLE;
        line_d = adv_line;
        col_d  = adv_col;
        off_d  = adv_off;
        if (is_bracket) begin
          main_v   = 1'b1;
          main_tok = make_tok((c == btok_pkg::CHAR_OPEN) ? btok_pkg::KIND_OPEN
                                                         : btok_pkg::KIND_CLOSE,
                              btok_pkg::ERR_NONE, line_q, col_q, off_q, len_t'(1));
        end else if (!is_space) begin
          tline_d = line_q;
          tcol_d  = col_q;
          toff_d  = off_q;
          len_d   = len_t'(1);
          if (is_digit) begin
            mode_d = MODE_INTEGER;
          end else if (is_quote) begin
            mode_d = MODE_STRING;
          end else begin
            mode_d = MODE_WORD;
          end
        end
      end
    end
  end

  always_comb begin
    tok_pair_o = '0;
    if (accept_i) begin
      if (pre_v && main_v) begin
        tok_pair_o.count              = 2'd2;
        tok_pair_o.first              = pre_tok;
        tok_pair_o.second             = main_tok;
        tok_pair_o.second.last_result = 1'b1;
      end else if (pre_v) begin
        tok_pair_o.count             = 2'd1;
        tok_pair_o.first             = pre_tok;
        tok_pair_o.first.last_result = 1'b1;
      end else if (main_v) begin
        tok_pair_o.count             = 2'd1;
        tok_pair_o.first             = main_tok;
        tok_pair_o.first.last_result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= pos_t'(1);
      col_q   <= pos_t'(1);
      off_q   <= '0;
      tline_q <= pos_t'(1);
      tcol_q  <= pos_t'(1);
      toff_q  <= '0;
      len_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      off_q   <= off_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      toff_q  <= toff_d;
      len_q   <= len_d;
    end
  end

endmodule

[sv/btok_token_fifo.sv]
module btok_token_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btok_pkg::token_pair_t push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output btok_pkg::out_word_t   out_word_o
);

  localparam int unsigned Depth = btok_pkg::TOKEN_FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  btok_pkg::out_word_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (count_q <= CntW'(Depth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[sv/bracket_word_tokenizer_unit.sv]
// Byte-serial tokenizer for bracketed text.
// Input channel (in_valid_i/in_ready_o/in_word_i): one text byte per word, or
// an end-of-text marker. Output channel (out_valid_o/out_ready_i/out_word_o):
// one token per word with kind, error code, start line/column/offset, length
// and a last_result flag on the final token caused by an input word.
// Each accepted byte updates the registered lexer state and pushes zero, one
// or two tokens into a four-entry token queue. A token is registered in the
// queue when its byte is accepted, and out_valid_o is high in the cycle after
// any push. The input takes one byte per cycle while the queue holds at most
// two tokens; the queue has a single read port, so bytes that cause two tokens
// can fill it faster than it drains, and in_ready_o then holds the input back.
// When the receiver stalls, tokens wait in the queue and in_ready_o drops once
// more than two are pending; nothing is lost.
// Reset clears the queue and returns the lexer to idle at line 1, column 1,
// offset 0. After an end-of-text marker the position counters carry on.
module bracket_word_tokenizer_unit #(
  parameter int unsigned POSITION_WIDTH = btok_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH   = btok_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  btok_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output btok_pkg::out_word_t out_word_o
);

  logic                  in_accept;
  btok_pkg::token_pair_t tok_pair;

  assign in_accept = in_valid_i && in_ready_o;

  btok_lexer #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_word_i (in_word_i),
    .tok_pair_o(tok_pair)
  );

  btok_token_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (tok_pair),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

`ifndef SYNTHESIS
  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |-> tok_pair.count == 2'd0)
    else $error("tokens pushed without an accepted word");

  a_pair_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pair.count != 2'd3)
    else $error("more than two tokens from one word");

  a_eot_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_word_i.end_of_text |-> tok_pair.count != 2'd0)
    else $error("end of text gave no token");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pair.count == 2'd2 |-> tok_pair.second.last_result && !tok_pair.first.last_result)
    else $error("last_result misplaced in token pair");

  a_out_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pair.count != 2'd0 |=> out_valid_o)
    else $error("pushed token not visible");
`endif

endmodule
